### rtl/rbre_pkg.sv
// Shared constants, types and helpers for the recent-byte run encoder.
package rbre_pkg;

	localparam int HIST_DEPTH = 8;
	localparam int POS_W      = $clog2(HIST_DEPTH);
	localparam int CODE_W     = 16;
	localparam int LEN_W      = 5;
	localparam logic [HIST_DEPTH-1:0] MASK_LIMIT = HIST_DEPTH'(7);

	// code lengths of the pieces that make up one result
	localparam logic [LEN_W-1:0] LEN_NONE    = LEN_W'(0);
	localparam logic [LEN_W-1:0] LEN_MATCH   = LEN_W'(1);
	localparam logic [LEN_W-1:0] LEN_CLOSE   = LEN_W'(4);
	localparam logic [LEN_W-1:0] LEN_CLOSE_R = LEN_W'(7);
	localparam logic [LEN_W-1:0] LEN_LITERAL = LEN_W'(9);

	// one history slot as it moves down the chain
	typedef struct packed {
		logic       vld;
		logic [7:0] data;
	} link_t;

	// one coded result handed from the coder to the output stage
	typedef struct packed {
		logic              present;
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
		logic              done;
	} result_t;

	// position of the lowest set bit (nearest match)
	function automatic logic [POS_W-1:0] nearest_pos(input logic [HIST_DEPTH-1:0] mask);
		logic [POS_W-1:0] pos;
		pos = '0;
		for (int k = HIST_DEPTH - 1; k >= 0; k--) begin
			if (mask[k]) begin
				pos = POS_W'(k);
			end
		end
		return pos;
	endfunction

endpackage

### rtl/rbre_cell.sv
// One history cell: stores a byte, compares it with the incoming byte, shifts on.
module rbre_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift_en,
	input  logic           clear,
	input  rbre_pkg::link_t prev,
	output rbre_pkg::link_t cur,
	input  logic [7:0]     probe,
	output logic           hit
);

	logic       vld_q;
	logic [7:0] data_q;

	// valid bit: cleared by reset or end of stream, else taken from neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clear) begin
			vld_q <= 1'b0;
		end else if (shift_en) begin
			vld_q <= prev.vld;
		end
	end

	// stored byte, guarded by vld_q
	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= prev.data;
		end
	end

	assign cur.vld  = vld_q;
	assign cur.data = data_q;
	assign hit      = vld_q && (data_q == probe);

endmodule

### rtl/rbre_coder.sv
// Hold and repeat tracking plus code assembly for one beat.
module rbre_coder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  logic                                eoi,
	input  logic [7:0]                          data,
	input  logic [rbre_pkg::HIST_DEPTH-1:0]     mask_raw,
	output rbre_pkg::result_t                   res
);

	logic                        hold_valid_q;
	logic [rbre_pkg::POS_W-1:0]  hold_pos_q;
	logic                        rep_valid_q;
	logic [2:0]                  rep_cnt_q;

	logic [rbre_pkg::HIST_DEPTH-1:0] mask;
	logic                            extend;
	logic [6:0]                      close_code;
	logic [rbre_pkg::LEN_W-1:0]      close_len;
	logic [8:0]                      cur_code;
	logic [rbre_pkg::LEN_W-1:0]      cur_len;
	logic [rbre_pkg::CODE_W-1:0]     close_wide;

	// end marker counts as no match
	assign mask   = eoi ? '0 : mask_raw;
	assign extend = hold_valid_q && mask[0] && (mask < rbre_pkg::MASK_LIMIT);

	// closing code of a pending hold
	always_comb begin
		close_code = '0;
		close_len  = rbre_pkg::LEN_NONE;
		if (hold_valid_q) begin
			if (rep_valid_q) begin
				close_code = {1'b1, hold_pos_q, rep_cnt_q};
				close_len  = rbre_pkg::LEN_CLOSE_R;
			end else begin
				close_code = {4'b0000, hold_pos_q};
				close_len  = rbre_pkg::LEN_CLOSE;
			end
		end
	end

	// code for the current byte
	always_comb begin
		if (eoi) begin
			cur_code = '0;
			cur_len  = rbre_pkg::LEN_NONE;
		end else if (mask == '0) begin
			cur_code = {1'b1, data};
			cur_len  = rbre_pkg::LEN_LITERAL;
		end else begin
			cur_code = '0;
			cur_len  = rbre_pkg::LEN_MATCH;
		end
	end

	// close code goes first, so it sits above the current code
	always_comb begin
		close_wide = rbre_pkg::CODE_W'(close_code);
		if (eoi) begin
			res.bits = close_wide;
		end else if (mask == '0) begin
			res.bits = (close_wide << 9) | rbre_pkg::CODE_W'(cur_code);
		end else begin
			res.bits = close_wide << 1;
		end
		res.present = !extend;
		res.len     = close_len + cur_len;
		res.done    = eoi;
	end

	// hold and repeat state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			hold_pos_q   <= '0;
			rep_valid_q  <= 1'b0;
			rep_cnt_q    <= '0;
		end else if (take) begin
			if (extend) begin
				if (rep_valid_q) begin
					rep_cnt_q <= rep_cnt_q + 3'd1;
				end else begin
					rep_valid_q <= 1'b1;
					rep_cnt_q   <= '0;
				end
			end else begin
				hold_valid_q <= !eoi && (mask != '0);
				hold_pos_q   <= eoi ? '0 : rbre_pkg::nearest_pos(mask);
				rep_valid_q  <= 1'b0;
				rep_cnt_q    <= '0;
			end
		end
	end

endmodule

### rtl/recent_byte_run_encoder_core.sv
// Top level of the recent-byte run encoder: history chain, coder and output skid.
//
//  channel | dir | tdata                                   | tlast
//  s_      | in  | [7:0] data_byte                         | end_of_input
//  m_      | out | [15:0] code_bits, [20:16] code_length   | stream_done
//
// One beat per cycle while s_tready is high; each result is registered.
// The eight-cell history chain compares and shifts in the same cycle as the coder.
// A beat that only extends a hold gives no output beat.
// A two-entry output stage (register plus skid) lets input continue under one
// stalled result; s_tready drops only while the skid entry is full.
// Reset clears the history valid bits and hold state at once; no init sweep.
module recent_byte_run_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] code_bits, [20:16] code_length, [23:21] zero
	output logic        m_tlast
);

	logic take;
	rbre_pkg::link_t [rbre_pkg::HIST_DEPTH:0] link;
	logic [rbre_pkg::HIST_DEPTH-1:0] mask;
	rbre_pkg::result_t res;

	logic              out_vld_q;
	rbre_pkg::result_t out_q;
	logic              skid_vld_q;
	rbre_pkg::result_t skid_q;

	assign take = s_tvalid && s_tready;

	// history chain: cell k holds the byte seen k+1 beats ago
	assign link[0].vld  = 1'b1;
	assign link[0].data = s_tdata;

	for (genvar k = 0; k < rbre_pkg::HIST_DEPTH; k++) begin : g_cell
		rbre_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (take && !s_tlast),
			.clear    (take && s_tlast),
			.prev     (link[k]),
			.cur      (link[k+1]),
			.probe    (s_tdata),
			.hit      (mask[k])
		);
	end

	rbre_coder u_coder (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.eoi      (s_tlast),
		.data     (s_tdata),
		.mask_raw (mask),
		.res      (res)
	);

	// output register and skid entry: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= take && res.present;
			end
		end else if (take && res.present) begin
			skid_vld_q <= 1'b1;
		end
	end

	// output register and skid entry: payload
	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (take && res.present) begin
			skid_q <= res;
		end
	end

	assign s_tready = !skid_vld_q;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, out_q.len, out_q.bits};
	assign m_tlast  = out_q.done;

endmodule
